FILE: design/knap_pkg.sv
// ----------------------------------------------------------------------------
// knap_pkg
// Shared sizes, state encoding and controller/datapath interface structs
// for the 0/1 knapsack engine.
// ----------------------------------------------------------------------------
package knap_pkg;

	localparam int MAX_ITEMS    = 32;
	localparam int MAX_CAPACITY = 255;
	localparam int VALUE_BITS   = 16;

	// fixed port widths
	localparam int WT_BITS     = 8;
	localparam int IN_VAL_BITS = 16;
	localparam int CAP_BITS    = 8;
	localparam int NUM_BITS    = 6;
	localparam int TOTAL_BITS  = 21;
	localparam int TOTAL_MAX   = (2 ** TOTAL_BITS) - 1;

	localparam int COLS       = MAX_CAPACITY + 1;
	localparam int COL_BITS   = $clog2(COLS);
	localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
	localparam int IDX_BITS   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int ROW_BITS   = VALUE_BITS + CNT_BITS;
	localparam int TAKE_DEPTH = MAX_ITEMS * COLS;
	localparam int TAKE_ABITS = $clog2(TAKE_DEPTH);
	localparam int CMP_A      = (WT_BITS > CAP_BITS) ? WT_BITS : CAP_BITS;
	localparam int CMP_BITS   = (CMP_A > COL_BITS) ? CMP_A : COL_BITS;
	localparam int SAT_BITS   = (ROW_BITS > TOTAL_BITS) ? ROW_BITS : TOTAL_BITS;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SWEEP   = 8'b0000_0010,
		S_DRAIN   = 8'b0000_0100,
		S_NEXT    = 8'b0000_1000,
		S_TOT_RD  = 8'b0001_0000,
		S_TOT_EV  = 8'b0010_0000,
		S_WALK_RD = 8'b0100_0000,
		S_WALK_EV = 8'b1000_0000
	} knap_state_t;

	typedef struct packed {
		logic load;       // latch input beat, store item or flag drop
		logic sweep;      // issue one column update, step column down
		logic bump;       // item fully written into the row
		logic tot_rd;     // read row at capacity, arm walk back
		logic tot_ev;     // capture total, stage the total result
		logic walk_rd;    // read take bit and stored item of next older item
		logic adopt;      // taken item becomes the pending result
		logic push;       // move pending result to the output register
		logic push_last;  // pushed result closes the job
		logic clear;      // end of job
	} knap_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic col_one;
		logic walk_done;
		logic take;
		logic out_free;
	} knap_sts_t;

	function automatic logic [TAKE_ABITS-1:0] take_addr(
		input logic [CNT_BITS-1:0] idx,
		input logic [COL_BITS-1:0] col
	);
		logic [TAKE_ABITS-1:0] base;
		base = TAKE_ABITS'(TAKE_ABITS'(idx) * TAKE_ABITS'(COLS));
		return TAKE_ABITS'(base + TAKE_ABITS'(col));
	endfunction

endpackage

FILE: design/knap_ctrl.sv
// ----------------------------------------------------------------------------
// knap_ctrl
// Sequencer: per-item row sweep, total readout and walk back over take bits.
// ----------------------------------------------------------------------------
module knap_ctrl
	import knap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  knap_sts_t sts,
	output knap_cmd_t cmd
);

	knap_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.full ? S_NEXT : S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.col_one) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last column write lands on this edge
				cmd.bump = 1'b1;
				state_d  = S_NEXT;
			end
			S_NEXT: begin
				state_d = sts.last ? S_TOT_RD : S_IDLE;
			end
			S_TOT_RD: begin
				cmd.tot_rd = 1'b1;
				state_d    = S_TOT_EV;
			end
			S_TOT_EV: begin
				cmd.tot_ev = 1'b1;
				state_d    = S_WALK_RD;
			end
			S_WALK_RD: begin
				if (sts.walk_done) begin
					if (sts.out_free) begin
						cmd.push      = 1'b1;
						cmd.push_last = 1'b1;
						cmd.clear     = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_EV;
				end
			end
			S_WALK_EV: begin
				if (!sts.take) begin
					state_d = S_WALK_RD;
				end else if (sts.out_free) begin
					cmd.push  = 1'b1;
					cmd.adopt = 1'b1;
					state_d   = S_WALK_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/knap_dp.sv
// ----------------------------------------------------------------------------
// knap_dp
// Datapath: best-value row memory, take-bit memory, item store, walk-back
// registers and the output register.
// ----------------------------------------------------------------------------
module knap_dp
	import knap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CAP_BITS-1:0]    cfg_wr_data,
	input  logic [WT_BITS-1:0]     item_weight_in,
	input  logic [IN_VAL_BITS-1:0] item_value_in,
	input  logic                   last_item,
	input  knap_cmd_t              cmd,
	output knap_sts_t              sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [NUM_BITS-1:0]    item_number,
	output logic [WT_BITS-1:0]     item_weight_out,
	output logic [IN_VAL_BITS-1:0] item_value_out,
	output logic [TOTAL_BITS-1:0]  best_total,
	output logic                   overflow,
	output logic                   last_result
);

	// configuration and job control
	logic [CAP_BITS-1:0]   cap_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  dropped_q;
	logic [WT_BITS-1:0]    wt_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  last_q;
	logic [COL_BITS-1:0]   col_q;

	// memories and item store
	logic [ROW_BITS-1:0]   row_mem [COLS];
	logic                  take_mem [TAKE_DEPTH];
	logic [WT_BITS-1:0]    wt_mem [MAX_ITEMS];
	logic [VALUE_BITS-1:0] val_mem [MAX_ITEMS];

	// sweep stage
	logic                  valid_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  fits_s1;
	logic                  zold_s1;
	logic                  zsrc_s1;
	logic [ROW_BITS-1:0]   old_rd_q;
	logic [ROW_BITS-1:0]   src_rd_q;

	// walk back
	logic [COL_BITS-1:0]   wlk_col_q;
	logic [CNT_BITS-1:0]   wlk_idx_q;
	logic                  take_rd_q;
	logic [WT_BITS-1:0]    cnd_wt_q;
	logic [VALUE_BITS-1:0] cnd_val_q;
	logic [CNT_BITS-1:0]   cnd_num_q;
	logic [TOTAL_BITS-1:0] total_q;

	// pending result: held until the next one is known so last can be marked
	logic                  pnd_kind_q;
	logic [CNT_BITS-1:0]   pnd_num_q;
	logic [WT_BITS-1:0]    pnd_wt_q;
	logic [VALUE_BITS-1:0] pnd_val_q;

	logic                  out_valid_q;

	logic [CMP_BITS-1:0]   cap_sat;
	logic [COL_BITS-1:0]   cap_col;
	logic                  fits;
	logic [COL_BITS-1:0]   src_col;
	logic [COL_BITS-1:0]   rd_a_addr;
	logic [ROW_BITS-1:0]   old_val;
	logic [ROW_BITS-1:0]   src_val;
	logic [ROW_BITS-1:0]   cand;
	logic                  take_now;
	logic [ROW_BITS-1:0]   new_val;
	logic [CNT_BITS-1:0]   idx_m1;
	logic                  cnd_fits;
	logic [COL_BITS-1:0]   col_left;
	logic [SAT_BITS-1:0]   tot_ext;
	logic [TOTAL_BITS-1:0] tot_sat;
	logic                  full;

	assign full = (count_q == CNT_BITS'(MAX_ITEMS));

	assign cap_sat = (CMP_BITS'(cap_q) > CMP_BITS'(MAX_CAPACITY)) ?
		CMP_BITS'(MAX_CAPACITY) : CMP_BITS'(cap_q);
	assign cap_col = COL_BITS'(cap_sat);

	assign fits      = (CMP_BITS'(wt_q) <= CMP_BITS'(col_q));
	assign src_col   = COL_BITS'(CMP_BITS'(col_q) - CMP_BITS'(wt_q));
	assign rd_a_addr = cmd.sweep ? col_q : cap_col;

	// first item of a job sees an all-zero row; column zero is always zero
	assign old_val  = zold_s1 ? '0 : old_rd_q;
	assign src_val  = zsrc_s1 ? '0 : src_rd_q;
	assign cand     = ROW_BITS'(ROW_BITS'(val_q) + src_val);
	assign take_now = fits_s1 && (cand > old_val);
	assign new_val  = take_now ? cand : old_val;

	assign idx_m1   = CNT_BITS'(wlk_idx_q - CNT_BITS'(1));
	assign cnd_fits = (CMP_BITS'(cnd_wt_q) <= CMP_BITS'(wlk_col_q));
	assign col_left = cnd_fits ?
		COL_BITS'(CMP_BITS'(wlk_col_q) - CMP_BITS'(cnd_wt_q)) : '0;

	assign tot_ext = SAT_BITS'(old_rd_q);
	assign tot_sat = (tot_ext > SAT_BITS'(TOTAL_MAX)) ?
		TOTAL_BITS'(TOTAL_MAX) : TOTAL_BITS'(tot_ext);

	// row memory: two registered reads, one write
	always_ff @(posedge clk) begin
		if (cmd.sweep || cmd.tot_rd) begin
			old_rd_q <= row_mem[rd_a_addr];
		end
		if (cmd.sweep) begin
			src_rd_q <= row_mem[src_col];
		end
		if (valid_s1) begin
			row_mem[col_s1] <= new_val;
		end
	end

	// take-bit memory
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			take_mem[take_addr(count_q, col_s1)] <= take_now;
		end
		if (cmd.walk_rd) begin
			take_rd_q <= take_mem[take_addr(idx_m1, wlk_col_q)];
		end
	end

	// item store
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			wt_mem[count_q[IDX_BITS-1:0]]  <= item_weight_in;
			val_mem[count_q[IDX_BITS-1:0]] <= VALUE_BITS'(item_value_in);
		end
		if (cmd.walk_rd) begin
			cnd_wt_q  <= wt_mem[idx_m1[IDX_BITS-1:0]];
			cnd_val_q <= val_mem[idx_m1[IDX_BITS-1:0]];
			cnd_num_q <= wlk_idx_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wt_q  <= item_weight_in;
			val_q <= VALUE_BITS'(item_value_in);
		end
		if (cmd.sweep) begin
			col_s1  <= col_q;
			fits_s1 <= fits;
			zold_s1 <= (count_q == '0);
			zsrc_s1 <= (count_q == '0) || (src_col == '0);
		end
		if (cmd.tot_ev) begin
			total_q    <= (cap_col == '0) ? '0 : tot_sat;
			pnd_kind_q <= 1'b0;
			pnd_num_q  <= '0;
			pnd_wt_q   <= '0;
			pnd_val_q  <= '0;
		end
		if (cmd.adopt) begin
			pnd_kind_q <= 1'b1;
			pnd_num_q  <= cnd_num_q;
			pnd_wt_q   <= cnd_wt_q;
			pnd_val_q  <= cnd_val_q;
		end
		if (cmd.push) begin
			kind            <= pnd_kind_q;
			item_number     <= NUM_BITS'(pnd_num_q);
			item_weight_out <= pnd_wt_q;
			item_value_out  <= IN_VAL_BITS'(pnd_val_q);
			best_total      <= total_q;
			overflow        <= dropped_q;
			last_result     <= cmd.push_last;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			last_q      <= 1'b0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
			wlk_col_q   <= '0;
			wlk_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			valid_s1 <= cmd.sweep;
			if (cmd.load) begin
				last_q <= last_item;
				col_q  <= COL_BITS'(MAX_CAPACITY);
				if (full) begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.sweep) begin
				col_q <= COL_BITS'(col_q - COL_BITS'(1));
			end
			if (cmd.bump) begin
				count_q <= CNT_BITS'(count_q + CNT_BITS'(1));
			end
			if (cmd.tot_rd) begin
				wlk_col_q <= cap_col;
				wlk_idx_q <= count_q;
			end else if (cmd.walk_rd) begin
				wlk_idx_q <= idx_m1;
			end
			if (cmd.adopt) begin
				wlk_col_q <= col_left;
			end
			if (cmd.clear) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts           = '0;
		sts.full      = full;
		sts.last      = last_q;
		sts.col_one   = (col_q == COL_BITS'(1));
		sts.walk_done = (wlk_idx_q == '0) || (wlk_col_q == '0);
		sts.take      = take_rd_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule

FILE: design/zero_one_knapsack_engine.sv
// ----------------------------------------------------------------------------
// zero_one_knapsack_engine
// 0/1 knapsack by dynamic programming, one item beat at a time.
// ----------------------------------------------------------------------------
// Each accepted item sweeps all MAX_CAPACITY columns of the best-value row,
// one column per cycle through a dual-read row memory, with the input
// stalled until the engine is idle again; an item dropped because MAX_ITEMS
// are already held skips the sweep. On the last item the engine reads the
// total and walks back over the take-bit memory, held by output stalls,
// emitting the total beat first and then each chosen item newest first;
// last_result marks the final beat. The row needs no clearing pass: the
// first item of a job treats it as zero. capacity is sampled on the last
// item.
module zero_one_knapsack_engine
	import knap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CAP_BITS-1:0]    cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WT_BITS-1:0]     item_weight_in,
	input  logic [IN_VAL_BITS-1:0] item_value_in,
	input  logic                   last_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [NUM_BITS-1:0]    item_number,
	output logic [WT_BITS-1:0]     item_weight_out,
	output logic [IN_VAL_BITS-1:0] item_value_out,
	output logic [TOTAL_BITS-1:0]  best_total,
	output logic                   overflow,
	output logic                   last_result
);

	knap_cmd_t cmd;
	knap_sts_t sts;

	knap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	knap_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.item_weight_in  (item_weight_in),
		.item_value_in   (item_value_in),
		.last_item       (last_item),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.item_number     (item_number),
		.item_weight_out (item_weight_out),
		.item_value_out  (item_value_out),
		.best_total      (best_total),
		.overflow        (overflow),
		.last_result     (last_result)
	);

endmodule

FILE: sim/tb_zero_one_knapsack_engine.sv
// ----------------------------------------------------------------------------
// tb_zero_one_knapsack_engine
// Self-checking bench for the 0/1 knapsack engine: directed jobs, then
// random jobs at several capacities under three idle/stall mixes. Every
// result beat is checked against a bench-side dynamic programming model.
// ----------------------------------------------------------------------------
module tb_zero_one_knapsack_engine
	import knap_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_PICK  = 1'b1;
	localparam int   SETTLE_CYC = 300;
	localparam int   WDOG_LIMIT = 20000;
	localparam int   ITEMS_PER_CAP = 26;

	typedef struct {
		logic [WT_BITS-1:0]     wt;
		logic [IN_VAL_BITS-1:0] val;
		logic                   last;
	} item_beat_t;

	typedef struct {
		logic                   kind;
		logic [NUM_BITS-1:0]    num;
		logic [WT_BITS-1:0]     wt;
		logic [IN_VAL_BITS-1:0] val;
		logic [TOTAL_BITS-1:0]  total;
		logic                   ovf;
		logic                   last;
	} result_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CAP_BITS-1:0]    cfg_wr_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [WT_BITS-1:0]     item_weight_in = '0;
	logic [IN_VAL_BITS-1:0] item_value_in = '0;
	logic                   last_item = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   kind;
	logic [NUM_BITS-1:0]    item_number;
	logic [WT_BITS-1:0]     item_weight_out;
	logic [IN_VAL_BITS-1:0] item_value_out;
	logic [TOTAL_BITS-1:0]  best_total;
	logic                   overflow;
	logic                   last_result;

	zero_one_knapsack_engine u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.item_weight_in  (item_weight_in),
		.item_value_in   (item_value_in),
		.last_item       (last_item),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.item_number     (item_number),
		.item_weight_out (item_weight_out),
		.item_value_out  (item_value_out),
		.best_total      (best_total),
		.overflow        (overflow),
		.last_result     (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the engine state
	logic [CAP_BITS-1:0]    cap_cfg = '0;
	logic [ROW_BITS-1:0]    best_row [COLS];
	bit                     taken [MAX_ITEMS][COLS];
	logic [WT_BITS-1:0]     kept_wt [MAX_ITEMS];
	logic [IN_VAL_BITS-1:0] kept_val [MAX_ITEMS];
	int                     held = 0;
	bit                     dropped = 0;

	item_beat_t   items_pend [$];
	result_beat_t beats_due [$];
	int           snd_idle_pct = 0;
	int           rcv_idle_pct = 0;
	bit           failed = 0;
	int           quiet_cyc = 0;

	initial foreach (best_row[c]) best_row[c] = '0;

	// one DP row update per held item, else a drop flag; on the last item, total plus walk back
	task automatic knap_take_item(input logic [WT_BITS-1:0] w,
			input logic [IN_VAL_BITS-1:0] v, input logic lst);
		logic [ROW_BITS:0]   cand;
		logic [ROW_BITS-1:0] tot;
		int                  cap;
		int                  rem;
		int                  idx;
		result_beat_t        b;
		result_beat_t        job_beats [$];
		if (held < MAX_ITEMS) begin
			kept_wt[held] = w;
			kept_val[held] = v;
			for (int col = MAX_CAPACITY; col >= 1; col--) begin
				taken[held][col] = 0;
				if (int'(w) <= col) begin
					cand = (ROW_BITS+1)'(v) + best_row[col - int'(w)];
					if (cand > best_row[col]) begin
						best_row[col] = cand[ROW_BITS-1:0];
						taken[held][col] = 1;
					end
				end
			end
			taken[held][0] = 0;
			held++;
		end else begin
			dropped = 1;
		end
		if (lst) begin
			cap = (int'(cap_cfg) > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_cfg);
			tot = best_row[cap];
			b.kind  = KIND_TOTAL;
			b.num   = '0;
			b.wt    = '0;
			b.val   = '0;
			b.total = (tot > TOTAL_MAX) ? TOTAL_BITS'(TOTAL_MAX) : TOTAL_BITS'(tot);
			b.ovf   = dropped;
			b.last  = 1'b0;
			job_beats.push_back(b);
			rem = cap;
			idx = held;
			while (idx > 0 && rem > 0) begin
				idx--;
				if (taken[idx][rem]) begin
					b.kind = KIND_PICK;
					b.num  = NUM_BITS'(idx + 1);
					b.wt   = kept_wt[idx];
					b.val  = kept_val[idx];
					job_beats.push_back(b);
					rem = (int'(kept_wt[idx]) <= rem) ? rem - int'(kept_wt[idx]) : 0;
				end
			end
			job_beats[job_beats.size() - 1].last = 1'b1;
			foreach (job_beats[k]) beats_due.push_back(job_beats[k]);
			foreach (best_row[c]) best_row[c] = '0;
			held = 0;
			dropped = 0;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		item_beat_t nx;
		if (!arst_n) begin
			in_valid <= 1'b0;
			item_weight_in <= '0;
			item_value_in <= '0;
			last_item <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				knap_take_item(item_weight_in, item_value_in, last_item);
			if (!in_valid || !in_stall) begin
				if (items_pend.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					nx = items_pend.pop_front();
					in_valid <= 1'b1;
					item_weight_in <= nx.wt;
					item_value_in <= nx.val;
					last_item <= nx.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint e, input longint a);
		if (e != a) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
			failed = 1;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_beat_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (beats_due.size() == 0) begin
					$display("%0t unexpected result beat: kind %0d item %0d total %0d",
						$time, kind, item_number, best_total);
					failed = 1;
				end else begin
					e = beats_due.pop_front();
					check_field("kind", e.kind, kind);
					check_field("item_number", e.num, item_number);
					check_field("item_weight_out", e.wt, item_weight_out);
					check_field("item_value_out", e.val, item_value_out);
					check_field("best_total", e.total, best_total);
					check_field("overflow", e.ovf, overflow);
					check_field("last_result", e.last, last_result);
				end
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cyc <= 0;
			else
				quiet_cyc <= quiet_cyc + 1;
			if (quiet_cyc >= WDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(input int w, input int v, input bit lst);
		item_beat_t it;
		it.wt = WT_BITS'(w);
		it.val = IN_VAL_BITS'(v);
		it.last = lst;
		items_pend.push_back(it);
	endtask

	// engine drained: no pending item, no result owed, then the clear time
	task automatic settle();
		do @(negedge clk);
		while (items_pend.size() != 0 || in_valid || beats_due.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_cap(input int c);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CAP_BITS'(c);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_cfg = CAP_BITS'(c);
		@(negedge clk);
	endtask

	function automatic int rand_weight(input int c);
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			2, 3, 4, 5, 6: return $urandom_range((c > 0) ? c : 1, 1);
			default: return $urandom_range(255);
		endcase
	endfunction

	function automatic int rand_value();
		case ($urandom_range(7))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// mostly short jobs; now and then one at or past the item limit
	task automatic make_job(input int c, inout int n);
		int len;
		if ($urandom_range(11) == 0)
			len = $urandom_range(MAX_ITEMS + 3, MAX_ITEMS);
		else
			len = $urandom_range(8, 1);
		for (int i = 0; i < len; i++)
			push_item(rand_weight(c), rand_value(), i == len - 1);
		n += (len < MAX_ITEMS) ? len : MAX_ITEMS;
	endtask

	initial begin
		int c;
		int n;
		snd_idle_pct = 7;
		rcv_idle_pct = 88;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero capacity: total only, even with a free item
		write_cap(0);
		push_item(10, 100, 1);
		push_item(0, 7, 1);
		settle();
		// full capacity, field extremes, zero-weight items
		write_cap(255);
		push_item(255, 65535, 0);
		push_item(0, 0, 0);
		push_item(0, 500, 0);
		push_item(1, 1, 0);
		push_item(254, 65534, 0);
		push_item(128, 300, 1);
		settle();
		// item heavier than capacity, zero value, exact fit
		write_cap(9);
		push_item(10, 999, 0);
		push_item(3, 5, 0);
		push_item(4, 6, 0);
		push_item(0, 0, 0);
		push_item(9, 11, 0);
		push_item(2, 0, 1);
		push_item(9, 42, 1);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 7; rcv_idle_pct = 88; end
				1: begin snd_idle_pct = 88; rcv_idle_pct = 7; end
				default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			endcase
			for (int s = 0; s < 4; s++) begin
				case (s)
					0: c = 255;
					1: c = $urandom_range(40, 1);
					2: c = 0;
					default: c = $urandom_range(255);
				endcase
				settle();
				write_cap(c);
				n = 0;
				while (n < ITEMS_PER_CAP)
					make_job(c, n);
			end
		end

		settle();
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/knap_pkg.sv
design/knap_ctrl.sv
design/knap_dp.sv
design/zero_one_knapsack_engine.sv
sim/tb_zero_one_knapsack_engine.sv
